### hdl/aet_pkg.sv
package aet_pkg;

  // number and position widths
  localparam int MANTISSA_WIDTH      = 32;
  localparam int MAX_FRACTION_DIGITS = 9;
  localparam int POSITION_WIDTH      = 16;
  localparam int FRAC_W              = 4;

  // token queue between lexer and token sequencer
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // token kinds
  localparam logic [2:0] KIND_NUMBER   = 3'd0;
  localparam logic [2:0] KIND_OPERATOR = 3'd1;
  localparam logic [2:0] KIND_LBRACKET = 3'd2;
  localparam logic [2:0] KIND_RBRACKET = 3'd3;
  localparam logic [2:0] KIND_END      = 3'd4;
  localparam logic [2:0] KIND_ERROR    = 3'd5;

  // operator codes
  localparam logic [2:0] OP_PLUS   = 3'd0;
  localparam logic [2:0] OP_MINUS  = 3'd1;
  localparam logic [2:0] OP_TIMES  = 3'd2;
  localparam logic [2:0] OP_DIVIDE = 3'd3;
  localparam logic [2:0] OP_MODULO = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_BAD_CHAR   = 2'd1;
  localparam logic [1:0] ERR_DOUBLE_OP  = 2'd2;
  localparam logic [1:0] ERR_DOUBLE_BRK = 2'd3;

  // characters
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } char_t;

  typedef struct packed {
    logic [2:0]                token_kind;
    logic [2:0]                operator_code;
    logic [MANTISSA_WIDTH-1:0] mantissa;
    logic [FRAC_W-1:0]         fraction_digits;
    logic                      mantissa_overflow;
    logic [1:0]                error_kind;
    logic [POSITION_WIDTH-1:0] error_position;
    logic                      last_of_run;
  } token_t;

  // all tokens caused by one character, in emit order: number, middle, end
  typedef struct packed {
    logic                      has_num;
    logic [MANTISSA_WIDTH-1:0] num_mant;
    logic [FRAC_W-1:0]         num_frac;
    logic                      num_ovf;
    logic                      has_mid;
    logic [2:0]                mid_kind;
    logic [2:0]                mid_op;
    logic [1:0]                mid_err;
    logic [POSITION_WIDTH-1:0] mid_pos;
    logic                      has_end;
  } bundle_t;

endpackage

### hdl/arith_expression_tokenizer.sv
// The first token of a character is written into the token queue and then loaded into
//   the output register, where it goes valid.
// Throughput: one character per cycle while each yields at most one token and the
//   output is not stalled; the output sends one token per cycle when not stalled, and
//   the four-entry token queue absorbs multi-token characters before char_stall rises.
// Reset: synchronous rst returns the lexer to idle at position 0 and empties the queue.
module arith_expression_tokenizer import aet_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   char_valid,
  output logic   char_stall,
  input  char_t  char_data,
  output logic   token_valid,
  input  logic   token_stall,
  output token_t token_data
);

  logic    accept;
  logic    push;
  logic    pop;
  logic    empty;
  logic    full;
  bundle_t push_data;
  bundle_t head;

  // input beat taken whenever the queue has room
  assign char_stall = full;
  assign accept     = char_valid && !char_stall;

  aet_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_data (char_data),
    .push      (push),
    .bundle    (push_data)
  );

  aet_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  aet_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_data  (token_data)
  );

endmodule

### hdl/aet_front.sv
module aet_front import aet_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  char_t   char_data,
  output logic    push,
  output bundle_t bundle
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_OPERATOR,
    MODE_BRACKET
  } mode_t;

  localparam int WIDE_W = MANTISSA_WIDTH + 4;

  mode_t                     mode, mode_next;
  logic                      halted, halted_next;
  logic [MANTISSA_WIDTH-1:0] accum, accum_next;
  logic [FRAC_W-1:0]         frac_count, frac_count_next;
  logic                      point_seen, point_seen_next;
  logic                      overflowed, overflowed_next;
  logic [POSITION_WIDTH-1:0] char_position;

  logic [7:0]        c;
  logic              eot;
  logic              is_digit, is_point, is_bracket, is_arith4, is_op, is_space;
  logic [2:0]        op_code;
  logic [3:0]        digit;
  logic [WIDE_W-1:0] accum_ext, wide;
  logic              digit_ovf;
  logic              idle_run;
  logic [1:0]        err;

  // character classes
  always_comb begin
    c          = char_data.char_in;
    eot        = char_data.end_of_text;
    is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    is_point   = (c == CH_POINT);
    is_bracket = (c == CH_LPAREN) || (c == CH_RPAREN);
    is_arith4  = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    is_op      = is_arith4 || (c == CH_PCT);
    is_space   = (c == CH_SPACE);
    digit      = 4'(c - CH_ZERO);
    case (c)
      CH_PLUS:  op_code = OP_PLUS;
      CH_MINUS: op_code = OP_MINUS;
      CH_STAR:  op_code = OP_TIMES;
      CH_SLASH: op_code = OP_DIVIDE;
      default:  op_code = OP_MODULO;
    endcase
  end

  // accum * 10 + digit as shift-add, overflow if any bit above the mantissa
  always_comb begin
    accum_ext = WIDE_W'(accum);
    wide      = (accum_ext << 3) + (accum_ext << 1) + WIDE_W'(digit);
    digit_ovf = |wide[WIDE_W-1:MANTISSA_WIDTH];
  end

  // lexer step
  always_comb begin
    mode_next       = mode;
    halted_next     = halted;
    accum_next      = accum;
    frac_count_next = frac_count;
    point_seen_next = point_seen;
    overflowed_next = overflowed;
    idle_run        = 1'b0;
    err             = ERR_NONE;
    bundle          = '0;

    if (!halted) begin
      case (mode)
        MODE_NUMBER: begin
          if (is_digit) begin
            if (!(point_seen && (frac_count >= FRAC_W'(MAX_FRACTION_DIGITS)))) begin
              if (point_seen) begin
                frac_count_next = frac_count + 1'b1;
              end
              if (digit_ovf) begin
                accum_next      = '1;
                overflowed_next = 1'b1;
              end else begin
                accum_next = wide[MANTISSA_WIDTH-1:0];
              end
            end
          end else if (is_point) begin
            if (point_seen) begin
              err = ERR_BAD_CHAR;
            end else begin
              point_seen_next = 1'b1;
            end
          end else begin
            bundle.has_num  = 1'b1;
            bundle.num_mant = accum;
            bundle.num_frac = frac_count;
            bundle.num_ovf  = overflowed;
            idle_run        = 1'b1;
          end
        end
        MODE_OPERATOR: begin
          if (is_arith4) begin
            err = ERR_DOUBLE_OP;
          end else begin
            idle_run = 1'b1;
          end
        end
        MODE_BRACKET: begin
          if (is_bracket) begin
            err = ERR_DOUBLE_BRK;
          end else begin
            idle_run = 1'b1;
          end
        end
        default: begin
          idle_run = 1'b1;
        end
      endcase

      // character lexed from idle
      if (idle_run) begin
        mode_next = MODE_IDLE;
        if (is_bracket) begin
          bundle.has_mid  = 1'b1;
          bundle.mid_kind = (c == CH_LPAREN) ? KIND_LBRACKET : KIND_RBRACKET;
          mode_next       = MODE_BRACKET;
        end else if (is_digit || is_point) begin
          accum_next      = is_point ? '0 : MANTISSA_WIDTH'(digit);
          frac_count_next = '0;
          overflowed_next = 1'b0;
          point_seen_next = is_point;
          mode_next       = MODE_NUMBER;
        end else if (is_op) begin
          bundle.has_mid  = 1'b1;
          bundle.mid_kind = KIND_OPERATOR;
          bundle.mid_op   = op_code;
          mode_next       = MODE_OPERATOR;
        end else if (!is_space) begin
          err = ERR_BAD_CHAR;
        end
      end

      // error halts until end of text, otherwise flush at end of text
      if (err != ERR_NONE) begin
        bundle.has_mid  = 1'b1;
        bundle.mid_kind = KIND_ERROR;
        bundle.mid_op   = OP_PLUS;
        bundle.mid_err  = err;
        bundle.mid_pos  = char_position;
        halted_next     = 1'b1;
        mode_next       = MODE_IDLE;
      end else if (eot) begin
        if (mode_next == MODE_NUMBER) begin
          bundle.has_num  = 1'b1;
          bundle.num_mant = accum_next;
          bundle.num_frac = frac_count_next;
          bundle.num_ovf  = overflowed_next;
        end
        bundle.has_end = 1'b1;
      end
    end

    push = accept && (bundle.has_num || bundle.has_mid || bundle.has_end);
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      halted        <= 1'b0;
      accum         <= '0;
      frac_count    <= '0;
      point_seen    <= 1'b0;
      overflowed    <= 1'b0;
      char_position <= '0;
    end else if (accept) begin
      if (char_data.end_of_text) begin
        mode          <= MODE_IDLE;
        halted        <= 1'b0;
        accum         <= '0;
        frac_count    <= '0;
        point_seen    <= 1'b0;
        overflowed    <= 1'b0;
        char_position <= '0;
      end else begin
        mode          <= mode_next;
        halted        <= halted_next;
        accum         <= accum_next;
        frac_count    <= frac_count_next;
        point_seen    <= point_seen_next;
        overflowed    <= overflowed_next;
        char_position <= char_position + 1'b1;
      end
    end
  end

  // a halted lexer always sits in idle
  a_halt_idle: assert property (@(posedge clk) disable iff (rst)
    halted |-> (mode == MODE_IDLE))
    else $error("halted lexer not in idle mode");

  // end of text rearms the lexer and restarts the position
  a_eot_rearm: assert property (@(posedge clk) disable iff (rst)
    (accept && char_data.end_of_text) |=> (!halted && (char_position == '0)))
    else $error("end of text did not rearm the lexer");

endmodule

### hdl/aet_queue.sv
module aet_queue import aet_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    empty,
  output logic    full
);

  bundle_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // no push into a full queue, no pop from an empty one
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("token queue overrun or underrun");

endmodule

### hdl/aet_back.sv
module aet_back import aet_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  bundle_t head,
  input  logic    empty,
  output logic    pop,
  output logic    token_valid,
  input  logic    token_stall,
  output token_t  token_data
);

  logic [2:0] done;
  logic [2:0] pending;
  logic [2:0] sel;
  logic       last;
  logic       load;
  token_t     tok;

  // pick the first token of the head bundle not yet sent
  always_comb begin
    pending = {head.has_end, head.has_mid, head.has_num} & ~done;
    if (pending[0]) begin
      sel = 3'b001;
    end else if (pending[1]) begin
      sel = 3'b010;
    end else begin
      sel = 3'b100;
    end
    last = ((pending & ~sel) == 3'b000);
    load = !empty && (!token_valid || !token_stall);
    pop  = load && last;

    tok = '0;
    if (sel[0]) begin
      tok.token_kind        = KIND_NUMBER;
      tok.mantissa          = head.num_mant;
      tok.fraction_digits   = head.num_frac;
      tok.mantissa_overflow = head.num_ovf;
    end else if (sel[1]) begin
      tok.token_kind     = head.mid_kind;
      tok.operator_code  = head.mid_op;
      tok.error_kind     = head.mid_err;
      tok.error_position = head.mid_pos;
    end else begin
      tok.token_kind = KIND_END;
    end
    tok.last_of_run = last;
  end

  // output register and progress through the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      done        <= '0;
    end else if (load) begin
      token_valid <= 1'b1;
      done        <= last ? 3'b000 : (done | sel);
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_data <= tok;
    end
  end

  // a queued bundle always has a token left to send
  a_head_pending: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pending != 3'b000))
    else $error("head bundle has nothing left to send");

  // the sent mask is cleared whenever a bundle retires
  a_done_clear: assert property (@(posedge clk) disable iff (rst)
    pop |=> (done == 3'b000))
    else $error("sent mask not cleared after bundle retired");

endmodule
